// ----- src/rrvke_pkg.sv -----
// Shared types and constants for the RESP request verb and key extractor.
// Depends on nothing; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package rrvke_pkg;

   // Parse phases, in the order a well-formed request walks through them.
   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_ARRAY = 3'd1,
      PH_HDR1  = 3'd2,
      PH_VERB  = 3'd3,
      PH_CRLF  = 3'd4,
      PH_HDR2  = 3'd5,
      PH_KEY   = 3'd6,
      PH_IDLE  = 3'd7
   } phase_type;

   // Verb and key buffer sizes. They are fixed by the result fields: a verb length
   // fits in four bits and a key length or character index in five.
   localparam int VERB_BYTES = 16;
   localparam int KEY_BYTES  = 32;

   // Result kinds carried on the result channel's tuser.
   localparam logic [1:0] KIND_VERB = 2'd0;
   localparam logic [1:0] KIND_KEY  = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // Protocol bytes.
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // One result as held in the output slots.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_value;
      logic [4:0] char_index;
      logic       accepted;
      logic [3:0] verb_length;
      logic [4:0] key_length;
      logic       last_result;
   } result_type;

endpackage

// ----- src/resp_request_verb_key_extractor_unit.sv -----
// Top level of the RESP request verb and key extractor: byte parser and result slots.
// Depends on rrvke_pkg for the phase type, result type and protocol constants.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_tvalid/tready   | tdata = data_byte, tlast = window_end
//  rsp     | out       | rsp_tvalid/tready   | tdata = char fields and lengths,
//          |           |                     | tuser = kind, tlast = last_result
//
// Each request byte is parsed in the cycle it is accepted; its results land in a
// two-entry result slot pair in the next cycle.
// A request that yields one result can be accepted every cycle while the consumer
// keeps up. A byte that yields two results (a character plus the end result) holds
// off the next byte until its second result is leaving through the single result port.
// Reset is synchronous and active high; it clears the parse state and empties the slots.
// A stall on rsp_tready holds the slots and deasserts req_tready until room returns.
module resp_request_verb_key_extractor_unit #(
   parameter int HEADER_SKIP_MAX = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // window_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_value, [12:8] char_index,
                                    // [13] accepted, [17:14] verb_length,
                                    // [22:18] key_length, [23] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_result
);

   // Counter widths follow from the limits they count up to.
   localparam int VCW = $clog2(rrvke_pkg::VERB_BYTES);
   localparam int KCW = $clog2(rrvke_pkg::KEY_BYTES);
   localparam int SCW = $clog2(HEADER_SKIP_MAX + 1);

   // Parse state.
   rrvke_pkg::phase_type phase_ff, phase_in;
   logic [SCW-1:0]       skip_ff, skip_in;
   logic [VCW-1:0]       verb_count_ff, verb_count_in;
   logic [KCW-1:0]       key_count_ff, key_count_in;
   logic [1:0]           crlf_count_ff, crlf_count_in;
   logic                 header_ok_ff, header_ok_in;
   logic                 verb_start_ok_ff, verb_start_ok_in;

   // Result slots: slot0 is always the head of the result stream.
   rrvke_pkg::result_type slot0_ff, slot0_in;
   rrvke_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]            count_ff, count_in;

   // Per-byte parse outcome.
   logic                  done;
   logic                  emit_char;
   logic [1:0]            char_kind;
   logic [7:0]            char_val;
   logic [4:0]            char_idx;
   logic                  is_crlf;
   logic                  accept;
   logic                  pop;
   rrvke_pkg::result_type char_res;
   rrvke_pkg::result_type end_res;

   assign is_crlf = (req_tdata == rrvke_pkg::CHAR_CR) || (req_tdata == rrvke_pkg::CHAR_LF);

   // A new byte may enter only when both its possible results fit: the slots are
   // empty, or the one result left is leaving in this cycle.
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // The byte is offered to the phases in order. A phase that does not consume the
   // byte moves on and leaves it for the next phase in the same cycle. Phases only
   // move forward, so one pass through the checks below covers every hand-off.
   always_comb begin
      phase_in         = phase_ff;
      skip_in          = skip_ff;
      verb_count_in    = verb_count_ff;
      key_count_in     = key_count_ff;
      crlf_count_in    = crlf_count_ff;
      header_ok_in     = header_ok_ff;
      verb_start_ok_in = verb_start_ok_ff;
      done             = 1'b0;
      emit_char        = 1'b0;
      char_kind        = rrvke_pkg::KIND_VERB;
      char_val         = req_tdata;
      char_idx         = 5'd0;

      // The window must open with an array marker; anything else parks the parse.
      if (phase_in == rrvke_pkg::PH_START) begin
         if (req_tdata == rrvke_pkg::CHAR_STAR) begin
            header_ok_in = 1'b1;
            skip_in      = SCW'(1);
            phase_in     = rrvke_pkg::PH_ARRAY;
         end else begin
            phase_in = rrvke_pkg::PH_IDLE;
         end
         done = 1'b1;
      end

      // The array header runs to a line feed or to the skip limit.
      if (!done && phase_in == rrvke_pkg::PH_ARRAY) begin
         skip_in = skip_in + SCW'(1);
         if (req_tdata == rrvke_pkg::CHAR_LF || skip_in >= SCW'(HEADER_SKIP_MAX)) begin
            skip_in  = '0;
            phase_in = rrvke_pkg::PH_HDR1;
         end
         done = 1'b1;
      end

      // Optional bulk header ahead of the verb.
      if (!done && phase_in == rrvke_pkg::PH_HDR1) begin
         if (skip_in == '0) begin
            if (req_tdata == rrvke_pkg::CHAR_DOLLAR) begin
               skip_in = SCW'(1);
               done    = 1'b1;
            end else begin
               phase_in = rrvke_pkg::PH_VERB;
            end
         end else begin
            skip_in = skip_in + SCW'(1);
            if (req_tdata == rrvke_pkg::CHAR_LF || skip_in >= SCW'(HEADER_SKIP_MAX)) begin
               skip_in  = '0;
               phase_in = rrvke_pkg::PH_VERB;
            end
            done = 1'b1;
         end
      end

      // Verb characters, folded to uppercase, until a line break or the verb is full.
      if (!done && phase_in == rrvke_pkg::PH_VERB) begin
         if (verb_count_in >= VCW'(rrvke_pkg::VERB_BYTES - 1) || is_crlf) begin
            phase_in = rrvke_pkg::PH_CRLF;
         end else begin
            if (req_tdata inside {[8'h61:8'h7A]}) begin
               char_val = req_tdata - rrvke_pkg::CASE_OFFSET;
            end
            if (verb_count_in == '0) begin
               verb_start_ok_in = (char_val inside {[8'h41:8'h5A]});
            end
            emit_char     = 1'b1;
            char_kind     = rrvke_pkg::KIND_VERB;
            char_idx      = 5'(verb_count_in);
            verb_count_in = verb_count_in + VCW'(1);
            done          = 1'b1;
         end
      end

      // Up to two line-break bytes between verb and key.
      if (!done && phase_in == rrvke_pkg::PH_CRLF) begin
         if (crlf_count_in < 2'd2 && is_crlf) begin
            crlf_count_in = crlf_count_in + 2'd1;
            done          = 1'b1;
         end else begin
            phase_in = rrvke_pkg::PH_HDR2;
         end
      end

      // Optional bulk header ahead of the key.
      if (!done && phase_in == rrvke_pkg::PH_HDR2) begin
         if (skip_in == '0) begin
            if (req_tdata == rrvke_pkg::CHAR_DOLLAR) begin
               skip_in = SCW'(1);
               done    = 1'b1;
            end else begin
               phase_in = rrvke_pkg::PH_KEY;
            end
         end else begin
            skip_in = skip_in + SCW'(1);
            if (req_tdata == rrvke_pkg::CHAR_LF || skip_in >= SCW'(HEADER_SKIP_MAX)) begin
               skip_in  = '0;
               phase_in = rrvke_pkg::PH_KEY;
            end
            done = 1'b1;
         end
      end

      // Key characters, verbatim, until a line break or the key is full.
      if (!done && phase_in == rrvke_pkg::PH_KEY) begin
         if (key_count_in >= KCW'(rrvke_pkg::KEY_BYTES - 1) || is_crlf) begin
            phase_in = rrvke_pkg::PH_IDLE;
         end else begin
            emit_char    = 1'b1;
            char_kind    = rrvke_pkg::KIND_KEY;
            char_idx     = 5'(key_count_in);
            key_count_in = key_count_in + KCW'(1);
         end
         done = 1'b1;
      end

      // Character result; it is the last one for this byte unless the window ends.
      char_res.kind        = char_kind;
      char_res.char_value  = char_val;
      char_res.char_index  = char_idx;
      char_res.accepted    = 1'b0;
      char_res.verb_length = 4'd0;
      char_res.key_length  = 5'd0;
      char_res.last_result = !req_tlast;

      // End result reports the counts as they stand after this byte.
      end_res.kind        = rrvke_pkg::KIND_END;
      end_res.char_value  = 8'd0;
      end_res.char_index  = 5'd0;
      end_res.accepted    = header_ok_in & verb_start_ok_in;
      end_res.verb_length = 4'(verb_count_in);
      end_res.key_length  = 5'(key_count_in);
      end_res.last_result = 1'b1;

      // The window's last byte returns the parser to its starting state.
      if (req_tlast) begin
         phase_in         = rrvke_pkg::PH_START;
         skip_in          = '0;
         verb_count_in    = '0;
         key_count_in     = '0;
         crlf_count_in    = 2'd0;
         header_ok_in     = 1'b0;
         verb_start_ok_in = 1'b0;
      end
   end

   // Slot loading: an accepted byte refills the slots from scratch, since it is only
   // accepted when they are empty after this cycle's pop. Otherwise a pop shifts up.
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (accept) begin
         slot0_in = emit_char ? char_res : end_res;
         slot1_in = end_res;
         count_in = {1'b0, emit_char} + {1'b0, req_tlast};
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= rrvke_pkg::PH_START;
         skip_ff          <= '0;
         verb_count_ff    <= '0;
         key_count_ff     <= '0;
         crlf_count_ff    <= 2'd0;
         header_ok_ff     <= 1'b0;
         verb_start_ok_ff <= 1'b0;
         count_ff         <= 2'd0;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            skip_ff          <= skip_in;
            verb_count_ff    <= verb_count_in;
            key_count_ff     <= key_count_in;
            crlf_count_ff    <= crlf_count_in;
            header_ok_ff     <= header_ok_in;
            verb_start_ok_ff <= verb_start_ok_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tdata = {1'b0, slot0_ff.key_length, slot0_ff.verb_length, slot0_ff.accepted,
                       slot0_ff.char_index, slot0_ff.char_value};
   assign rsp_tuser = slot0_ff.kind;
   assign rsp_tlast = slot0_ff.last_result;

`ifndef ASSERT_OFF
   // An end result always closes the results of its byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == rrvke_pkg::KIND_END) |-> rsp_tlast)
      else $error("end result without last_result");

   // Two queued results are always a character followed by the end result.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> (slot1_ff.kind == rrvke_pkg::KIND_END &&
                              slot0_ff.kind != rrvke_pkg::KIND_END && !slot0_ff.last_result))
      else $error("second result slot holds something other than an end result");

   // The verb counter never passes its limit.
   assert property (@(posedge clock) disable iff (reset)
      verb_count_ff <= VCW'(rrvke_pkg::VERB_BYTES - 1))
      else $error("verb counter past its limit");
`endif

endmodule

// ----- tb/rrvke_parse_checker.sv -----
// Checker for the RESP request verb and key extractor: predicts the result stream.
// Depends on rrvke_pkg for the phase type, result type and protocol constants.
`timescale 1ns / 1ps

module rrvke_parse_checker #(
   parameter int HEADER_SKIP_MAX = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          results_owed
);

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   // Shadow copy of the parse state.
   rrvke_pkg::phase_type parse_phase = rrvke_pkg::PH_START;
   logic [3:0] skip_cnt    = '0;
   logic [3:0] verb_cnt    = '0;
   logic [4:0] key_cnt     = '0;
   logic [1:0] break_cnt   = '0;
   logic       star_seen   = 1'b0;
   logic       verb_lead_ok = 1'b0;

   rrvke_pkg::result_type expected_results[$];
   int         fail_tally = 0;
   int         owed = 0;

   assign mismatch_count = fail_tally;
   assign results_owed   = owed;

   function automatic logic is_line_break(input logic [7:0] b);
      return b == rrvke_pkg::CHAR_CR || b == rrvke_pkg::CHAR_LF;
   endfunction

   function automatic void clear_parse();
      parse_phase  = rrvke_pkg::PH_START;
      skip_cnt     = '0;
      verb_cnt     = '0;
      key_cnt      = '0;
      break_cnt    = '0;
      star_seen    = 1'b0;
      verb_lead_ok = 1'b0;
   endfunction

   function automatic void queue_char(input logic [1:0] kind, input logic [7:0] ch,
                                      input logic [4:0] idx, input logic win_end);
      rrvke_pkg::result_type r;
      r            = '0;
      r.kind       = kind;
      r.char_value = ch;
      r.char_index = idx;
      r.last_result = !win_end;
      expected_results.push_back(r);
   endfunction

   // Optional bulk header: a '$' starts a skip that ends after a line feed or
   // when the skip budget runs out. Returns 1 when the byte falls through.
   function automatic logic skip_bulk_header(input logic [7:0] b,
                                             input rrvke_pkg::phase_type next_phase);
      if (skip_cnt == 0) begin
         if (b == rrvke_pkg::CHAR_DOLLAR) begin
            skip_cnt = 4'd1;
            return 1'b0;
         end
         parse_phase = next_phase;
         return 1'b1;
      end
      skip_cnt = skip_cnt + 4'd1;
      if (b == rrvke_pkg::CHAR_LF || skip_cnt >= HEADER_SKIP_MAX) begin
         skip_cnt    = '0;
         parse_phase = next_phase;
      end
      return 1'b0;
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic win_end);
      logic       carry;
      logic [7:0] up;
      rrvke_pkg::result_type r;
      carry = 1'b1;
      while (carry) begin
         carry = 1'b0;
         case (parse_phase)
            rrvke_pkg::PH_START: begin
               if (b == rrvke_pkg::CHAR_STAR) begin
                  star_seen   = 1'b1;
                  skip_cnt    = 4'd1;
                  parse_phase = rrvke_pkg::PH_ARRAY;
               end else begin
                  parse_phase = rrvke_pkg::PH_IDLE;
               end
            end
            rrvke_pkg::PH_ARRAY: begin
               skip_cnt = skip_cnt + 4'd1;
               if (b == rrvke_pkg::CHAR_LF || skip_cnt >= HEADER_SKIP_MAX) begin
                  skip_cnt    = '0;
                  parse_phase = rrvke_pkg::PH_HDR1;
               end
            end
            rrvke_pkg::PH_HDR1: carry = skip_bulk_header(b, rrvke_pkg::PH_VERB);
            rrvke_pkg::PH_VERB: begin
               if (verb_cnt >= rrvke_pkg::VERB_BYTES - 1 || is_line_break(b)) begin
                  parse_phase = rrvke_pkg::PH_CRLF;
                  carry       = 1'b1;
               end else begin
                  up = (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ?
                       b - rrvke_pkg::CASE_OFFSET : b;
                  if (verb_cnt == 0)
                     verb_lead_ok = up >= CHAR_UPPER_A && up <= CHAR_UPPER_Z;
                  queue_char(rrvke_pkg::KIND_VERB, up, 5'(verb_cnt), win_end);
                  verb_cnt = verb_cnt + 4'd1;
               end
            end
            rrvke_pkg::PH_CRLF: begin
               if (break_cnt < 2 && is_line_break(b)) begin
                  break_cnt = break_cnt + 2'd1;
               end else begin
                  parse_phase = rrvke_pkg::PH_HDR2;
                  carry       = 1'b1;
               end
            end
            rrvke_pkg::PH_HDR2: carry = skip_bulk_header(b, rrvke_pkg::PH_KEY);
            rrvke_pkg::PH_KEY: begin
               if (key_cnt >= rrvke_pkg::KEY_BYTES - 1 || is_line_break(b)) begin
                  parse_phase = rrvke_pkg::PH_IDLE;
               end else begin
                  queue_char(rrvke_pkg::KIND_KEY, b, key_cnt, win_end);
                  key_cnt = key_cnt + 5'd1;
               end
            end
            default: ;
         endcase
      end
      if (win_end) begin
         r             = '0;
         r.kind        = rrvke_pkg::KIND_END;
         r.accepted    = star_seen & verb_lead_ok;
         r.verb_length = verb_cnt;
         r.key_length  = key_cnt;
         r.last_result = 1'b1;
         expected_results.push_back(r);
         clear_parse();
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_tally++;
      end
   endfunction

   always @(posedge clock) begin
      rrvke_pkg::result_type want;
      if (reset) begin
         clear_parse();
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, kind %0h data %0h", $time, rsp_tuser,
                        rsp_tdata);
               fail_tally++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("char_value", want.char_value, rsp_tdata[7:0]);
               check_field("char_index", want.char_index, rsp_tdata[12:8]);
               check_field("accepted", want.accepted, rsp_tdata[13]);
               check_field("verb_length", want.verb_length, rsp_tdata[17:14]);
               check_field("key_length", want.key_length, rsp_tdata[22:18]);
               check_field("pad bit", 0, rsp_tdata[23]);
               check_field("last_result", want.last_result, rsp_tlast);
            end
         end
      end
      owed <= expected_results.size();
   end

endmodule

// ----- tb/tb_resp_request_verb_key_extractor_unit.sv -----
// Testbench top for the RESP request verb and key extractor: stimulus and verdict.
// Depends on rrvke_pkg, the extractor top level and the rrvke_parse_checker module.
`timescale 1ns / 1ps

module tb_resp_request_verb_key_extractor_unit;

   localparam int HEADER_SKIP_MAX = 8;

   // Printable characters used to build request text.
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_BRACE   = 8'h7B;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatches;
   int results_owed;

   // While calm is set neither side idles. Setting squeeze_armed asks the
   // receiver for one long hold-off so that the block backs up onto its input.
   bit calm          = 1'b0;
   bit squeeze_armed = 1'b0;

   int         bytes_sent = 0;
   logic [7:0] frame_bytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   resp_request_verb_key_extractor_unit #(
      .HEADER_SKIP_MAX (HEADER_SKIP_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   rrvke_parse_checker #(
      .HEADER_SKIP_MAX (HEADER_SKIP_MAX)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatches),
      .results_owed   (results_owed)
   );

   // Any byte except CR and LF, so that runs of text are not cut short.
   function automatic logic [7:0] text_byte();
      logic [7:0] v;
      do
         v = 8'($urandom_range(255));
      while (v == rrvke_pkg::CHAR_CR || v == rrvke_pkg::CHAR_LF);
      return v;
   endfunction

   function automatic void push_digits(input int count);
      repeat (count) frame_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
   endfunction

   function automatic void push_line_end();
      frame_bytes.push_back(rrvke_pkg::CHAR_CR);
      frame_bytes.push_back(rrvke_pkg::CHAR_LF);
   endfunction

   // A '$' bulk header such as "$3\r\n". Now and then the line feed is left
   // out so that the skip only stops when its budget runs out.
   function automatic void push_bulk_header();
      frame_bytes.push_back(rrvke_pkg::CHAR_DOLLAR);
      push_digits($urandom_range(0, 2));
      if ($urandom_range(5) == 0)
         push_digits($urandom_range(4, 9));
      else
         push_line_end();
   endfunction

   // Builds one well-formed request with random content: array header, optional
   // bulk headers, verb, line break, key and a short tail. Some windows are cut
   // off at a random point so that the end arrives in the middle of the parse.
   function automatic void build_request();
      int verb_len;
      int key_len;
      int keep;
      frame_bytes.push_back(rrvke_pkg::CHAR_STAR);
      push_digits($urandom_range(0, 9));
      case ($urandom_range(3))
         0: frame_bytes.push_back(rrvke_pkg::CHAR_LF);
         1: ;
         default: push_line_end();
      endcase
      if ($urandom_range(1))
         push_bulk_header();
      verb_len = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 8);
      repeat (verb_len) begin
         case ($urandom_range(7))
            0: frame_bytes.push_back(text_byte());
            1, 2, 3: frame_bytes.push_back(CHAR_UPPER_A + 8'($urandom_range(25)));
            default: frame_bytes.push_back(CHAR_LOWER_A + 8'($urandom_range(25)));
         endcase
      end
      // The line break after the verb: sometimes three bytes, which is one
      // more than the parser steps over.
      case ($urandom_range(4))
         0: frame_bytes.push_back(rrvke_pkg::CHAR_LF);
         1: begin
            frame_bytes.push_back(rrvke_pkg::CHAR_CR);
            push_line_end();
         end
         2: ;
         default: push_line_end();
      endcase
      if ($urandom_range(1))
         push_bulk_header();
      key_len = ($urandom_range(9) == 0) ? $urandom_range(29, 35) : $urandom_range(0, 10);
      repeat (key_len) frame_bytes.push_back(text_byte());
      push_line_end();
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(7) == 0) begin
         keep = $urandom_range(1, frame_bytes.size());
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
   endfunction

   // Offers one request byte and waits until it has been accepted. Gaps are
   // inserted before the byte, so valid is never lowered and raised in one step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      frame_bytes.delete();
   endtask

   // Most random windows are well-formed requests; the rest are noise, which
   // sometimes starts with '*' so that the header phases see garbage too.
   task automatic send_random_window();
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(255)));
         if ($urandom_range(1))
            frame_bytes[0] = rrvke_pkg::CHAR_STAR;
      end else begin
         build_request();
      end
      send_frame();
   endtask

   // The receiver stalls at random, except for one long hold-off counted here
   // and the calm stretch.
   initial begin
      int hold_left;
      bit squeeze_taken;
      hold_left     = 0;
      squeeze_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (squeeze_armed && !squeeze_taken) begin
            squeeze_taken = 1'b1;
            hold_left     = 200;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 27;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A window that does not start with '*' is rejected outright.
      frame_bytes.push_back(CHAR_UPPER_A + 8'd23);
      send_frame();
      // The window ends on its very first byte, the array marker.
      frame_bytes.push_back(rrvke_pkg::CHAR_STAR);
      send_frame();
      // Lowercase verb without a bulk header; the window ends on a key byte,
      // so that byte yields a key character and the end result together.
      frame_bytes.push_back(rrvke_pkg::CHAR_STAR);
      frame_bytes.push_back(rrvke_pkg::CHAR_LF);
      frame_bytes.push_back(CHAR_LOWER_A + 8'd6);
      frame_bytes.push_back(CHAR_LOWER_A + 8'd4);
      frame_bytes.push_back(CHAR_LOWER_A + 8'd19);
      push_line_end();
      frame_bytes.push_back(CHAR_LOWER_A + 8'd10);
      send_frame();
      // A verb that begins with a digit is not accepted.
      frame_bytes.push_back(rrvke_pkg::CHAR_STAR);
      frame_bytes.push_back(rrvke_pkg::CHAR_LF);
      frame_bytes.push_back(CHAR_ZERO + 8'd1);
      frame_bytes.push_back(rrvke_pkg::CHAR_LF);
      send_frame();
      // An empty verb is not accepted either.
      frame_bytes.push_back(rrvke_pkg::CHAR_STAR);
      frame_bytes.push_back(rrvke_pkg::CHAR_LF);
      frame_bytes.push_back(rrvke_pkg::CHAR_LF);
      send_frame();
      // Bulk header, then verb bytes at the top and bottom of the byte range
      // and one just past the lowercase letters.
      frame_bytes.push_back(rrvke_pkg::CHAR_STAR);
      frame_bytes.push_back(rrvke_pkg::CHAR_LF);
      frame_bytes.push_back(rrvke_pkg::CHAR_DOLLAR);
      frame_bytes.push_back(rrvke_pkg::CHAR_LF);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(CHAR_BRACE);
      frame_bytes.push_back(8'h00);
      send_frame();

      while (bytes_sent < 250) send_random_window();
      // A stretch in which neither side idles.
      calm = 1'b1;
      while (bytes_sent < 400) send_random_window();
      calm = 1'b0;
      // The receiver now holds off for a long time while requests keep coming.
      squeeze_armed = 1'b1;
      while (bytes_sent < 600) send_random_window();
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && results_owed == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Far beyond the slowest correct run of roughly 600 request bytes.
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
